// ===== rtl/core/csvt_pkg.sv =====
// Shared types and constants of the CSV field tokenizer.
`timescale 1ns / 1ps
package csvt_pkg;

  // Byte codes that the tokenizer always recognizes
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;

  // Register reset values
  localparam logic [7:0] SEP_RESET   = 8'd44;
  localparam logic [7:0] DELIM_RESET = 8'd34;

  // Field widths
  localparam int ROW_W     = 24;
  localparam int COL_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 8;

  localparam logic [ROW_W-1:0] ROW_LIMIT = '1;

  // Command queue between classifier and sequencer
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEP_A = 2'd0,
    REG_SEP_B = 2'd1,
    REG_DELIM = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_FEND = 2'd1,
    KIND_TEND = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    MODE_START  = 3'b001,
    MODE_PLAIN  = 3'b010,
    MODE_QUOTED = 3'b100
  } mode_t;

  // Classified input item
  typedef struct packed {
    logic       flush;
    logic       is_cr;
    logic       is_lf;
    logic       is_ws;
    logic       is_delim;
    logic       is_sep;
    logic [7:0] data;
  } cmd_t;

  // One result item
  typedef struct packed {
    kind_t             kind;
    logic [7:0]        char_value;
    logic [ROW_W-1:0]  row_index;
    logic [COL_W-1:0]  column_index;
    logic              last_in_row;
    logic              pending_overflow;
    logic              last;
  } res_t;

  // Sequencer status
  typedef struct packed {
    logic idle;
    logic line_open;
  } stat_t;

endpackage

// ===== rtl/core/csvt_if.sv =====
// Stream interfaces of the CSV field tokenizer: byte input and result output.
`timescale 1ns / 1ps
interface csvt_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] in_byte;

  modport source (output valid, output op, output in_byte, input ready);
  modport sink   (input valid, input op, input in_byte, output ready);
endinterface

interface csvt_out_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   kind;
  logic [7:0]                   char_value;
  logic [csvt_pkg::ROW_W-1:0]   row_index;
  logic [csvt_pkg::COL_W-1:0]   column_index;
  logic                         last_in_row;
  logic                         pending_overflow;
  logic                         last;

  modport source (output valid, output kind, output char_value, output row_index,
                  output column_index, output last_in_row, output pending_overflow,
                  output last, input ready);
  modport sink   (input valid, input kind, input char_value, input row_index,
                  input column_index, input last_in_row, input pending_overflow,
                  input last, output ready);
endinterface

// ===== rtl/core/csv_field_tokenizer.sv =====
// Top level of the CSV field tokenizer: classifier, command queue and sequencer.
// Each byte is queued, then decoded by the sequencer into the output register.
// Throughput: one byte per cycle while the queue has room; a byte that releases
// a pending trim run holds the sequencer until the run and its result are out,
// plus a table end at end of input; meanwhile the queue holds up to four bytes.
// Reset (rst, synchronous): all stream state cleared, registers back to 44/44/34.
`timescale 1ns / 1ps
module csv_field_tokenizer #(
  parameter int PENDING_DEPTH = 32,
  parameter int MAX_COLUMNS   = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  csvt_in_if.sink                        in_ch,
  csvt_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [csvt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [csvt_pkg::CFG_W-1:0]     cfg_data
);
  import csvt_pkg::*;

  logic       push;
  cmd_t       push_cmd;
  logic       q_full;
  logic       cmd_pop;
  logic       cmd_valid;
  cmd_t       cmd;
  logic [7:0] text_delim;
  stat_t      stat;

  // Classify incoming bytes
  csvt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_full     (q_full),
    .push       (push),
    .push_cmd   (push_cmd),
    .text_delim (text_delim)
  );

  // Buffer commands
  csvt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (cmd_pop),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  // Execute commands and emit results
  csvt_back #(
    .PENDING_DEPTH (PENDING_DEPTH),
    .MAX_COLUMNS   (MAX_COLUMNS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .text_delim (text_delim),
    .out_ch     (out_ch),
    .stat       (stat)
  );

  // Commands leave the queue only when present and the sequencer is free
  a_pop_ok: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> (cmd_valid && stat.idle))
    else $error("command popped while queue empty or sequencer busy");

  // Only field characters carry a character value
  a_char_zero: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.kind != KIND_CHAR) |-> (out_ch.char_value == 8'h00))
    else $error("nonzero character on a non-character result");

  // Table end closes its step and never marks a row end
  a_tend_last: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.kind == KIND_TEND) |-> (out_ch.last && !out_ch.last_in_row))
    else $error("table end result with wrong markers");

  // A line opens only on a consumed byte
  a_line_open: assert property (@(posedge clk) disable iff (rst)
    $rose(stat.line_open) |-> $past(cmd_pop))
    else $error("line opened without a command");

endmodule

// ===== rtl/core/csvt_front.sv =====
// Input stage: configuration registers and byte classification into commands.
`timescale 1ns / 1ps
module csvt_front (
  input  logic                           clk,
  input  logic                           rst,
  csvt_in_if.sink                        in_ch,
  input  logic                           cfg_we,
  input  logic [csvt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [csvt_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           q_full,
  output logic                           push,
  output csvt_pkg::cmd_t                 push_cmd,
  output logic [7:0]                     text_delim
);
  import csvt_pkg::*;

  logic [7:0] separator_a;
  logic [7:0] separator_b;
  logic [7:0] delim;

  // Register writes; an index past the list is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      separator_a <= SEP_RESET;
      separator_b <= SEP_RESET;
      delim       <= DELIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SEP_A: separator_a <= cfg_data;
        REG_SEP_B: separator_b <= cfg_data;
        REG_DELIM: delim       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Accept while the queue has room
  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  // Classify the byte against the current registers
  always_comb begin
    push_cmd.flush    = in_ch.op;
    push_cmd.is_cr    = (in_ch.in_byte == CH_CR);
    push_cmd.is_lf    = (in_ch.in_byte == CH_LF);
    push_cmd.is_ws    = (in_ch.in_byte == CH_SP) || (in_ch.in_byte == CH_TAB);
    push_cmd.is_delim = (in_ch.in_byte == delim);
    push_cmd.is_sep   = (in_ch.in_byte == separator_a) || (in_ch.in_byte == separator_b);
    push_cmd.data     = in_ch.in_byte;
  end

  assign text_delim = delim;

endmodule

// ===== rtl/core/csvt_queue.sv =====
// Short command queue that decouples the classifier from the sequencer.
`timescale 1ns / 1ps
module csvt_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  csvt_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           cmd_valid,
  output csvt_pkg::cmd_t cmd
);
  import csvt_pkg::*;

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full      = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = entries[rd_ptr];

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and track fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

// ===== rtl/core/csvt_back.sv =====
// Sequencer: field, line and trim state, and emission of result items.
`timescale 1ns / 1ps
module csvt_back #(
  parameter int PENDING_DEPTH = 32,
  parameter int MAX_COLUMNS   = 1024
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  csvt_pkg::cmd_t cmd,
  output logic           cmd_pop,
  input  logic [7:0]     text_delim,
  csvt_out_if.source     out_ch,
  output csvt_pkg::stat_t stat
);
  import csvt_pkg::*;

  localparam int PCNT_W = $clog2(PENDING_DEPTH + 1);
  localparam int PIDX_W = $clog2(PENDING_DEPTH);
  localparam int CCNT_W = $clog2(MAX_COLUMNS + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_PEND = 3'b010,
    ST_FIN  = 3'b100
  } bst_t;

  // Control state
  bst_t                 state, state_next;
  mode_t                mode, mode_next;
  logic [PENDING_DEPTH-1:0] kinds, kinds_next;
  logic [PCNT_W-1:0]    pcnt, pcnt_next;
  logic                 tail_kind, tail_kind_next;
  logic                 content_seen, content_seen_next;
  logic                 line_open, line_open_next;
  logic                 after_cr, after_cr_next;
  logic [ROW_W-1:0]     row_count, row_count_next;
  logic [CCNT_W-1:0]    col_count, col_count_next;
  logic [CCNT_W-1:0]    col_max, col_max_next;
  logic                 overflow_seen, overflow_seen_next;
  logic [PCNT_W-1:0]    pend_left, pend_left_next;
  logic                 out_valid, out_valid_next;

  // Plan of the command in progress
  kind_t                plan_act, plan_act_next;
  logic                 plan_lir, plan_lir_next;
  logic                 plan_flush, plan_flush_next;
  logic [7:0]           plan_byte, plan_byte_next;
  res_t                 out_data, out_data_next;

  // Decode results
  logic [PCNT_W-1:0]    trim_cnt;
  logic [PCNT_W-1:0]    dec_pend;
  logic                 dec_res;
  kind_t                dec_act;
  logic                 dec_lir;
  mode_t                dec_mode;
  logic                 do_feed;
  logic                 do_push;
  logic                 push_kind;

  // Emission control
  logic                 out_free;
  logic                 fin_go;
  logic                 pend_go;
  kind_t                fin_act;
  logic                 fin_lir;
  logic                 fin_flush;
  logic [7:0]           fin_byte;
  logic [CCNT_W-1:0]    col_inc;
  res_t                 emit;

  assign out_free = !out_valid || out_ch.ready;
  assign col_inc  = (col_count < CCNT_W'(MAX_COLUMNS)) ? col_count + CCNT_W'(1) : col_count;

  // Decode the head command against the field state
  always_comb begin
    trim_cnt  = pcnt - {{(PCNT_W-1){1'b0}}, (pcnt != '0) && !tail_kind};
    dec_pend  = '0;
    dec_res   = 1'b0;
    dec_act   = KIND_CHAR;
    dec_lir   = 1'b0;
    dec_mode  = mode;
    do_feed   = 1'b0;
    do_push   = 1'b0;
    push_kind = 1'b0;
    if (cmd.flush) begin
      dec_res = 1'b1;
      if (line_open) begin
        dec_act  = KIND_FEND;
        dec_lir  = 1'b1;
        dec_pend = content_seen ? '0 : trim_cnt;
      end else begin
        dec_act = KIND_TEND;
      end
    end else if (after_cr && cmd.is_lf) begin
      // second half of a CR LF pair
    end else if (cmd.is_cr || cmd.is_lf) begin
      if (line_open) begin
        dec_res  = 1'b1;
        dec_act  = KIND_FEND;
        dec_lir  = 1'b1;
        dec_pend = content_seen ? '0 : trim_cnt;
      end
    end else begin
      priority if (mode == MODE_QUOTED) begin
        do_feed = 1'b1;
        if (cmd.is_delim) begin
          dec_mode = MODE_PLAIN;
        end
      end else if (mode == MODE_START && cmd.is_delim) begin
        dec_mode = MODE_QUOTED;
        do_feed  = 1'b1;
      end else if (cmd.is_sep) begin
        dec_res  = 1'b1;
        dec_act  = KIND_FEND;
        dec_pend = content_seen ? '0 : trim_cnt;
      end else begin
        dec_mode = MODE_PLAIN;
        do_feed  = 1'b1;
      end
      if (do_feed) begin
        priority if (cmd.is_ws) begin
          // drop leading whitespace and collapse runs
          do_push = !(!content_seen && pcnt == '0) && !(pcnt != '0 && !tail_kind);
        end else if (cmd.is_delim) begin
          do_push   = 1'b1;
          push_kind = 1'b1;
        end else begin
          dec_res  = 1'b1;
          dec_act  = KIND_CHAR;
          dec_pend = content_seen ? pcnt : '0;
        end
      end
    end
  end

  // Sequence one command and update state
  always_comb begin
    state_next         = state;
    mode_next          = mode;
    kinds_next         = kinds;
    pcnt_next          = pcnt;
    tail_kind_next     = tail_kind;
    content_seen_next  = content_seen;
    line_open_next     = line_open;
    after_cr_next      = after_cr;
    row_count_next     = row_count;
    col_count_next     = col_count;
    col_max_next       = col_max;
    overflow_seen_next = overflow_seen;
    pend_left_next     = pend_left;
    plan_act_next      = plan_act;
    plan_lir_next      = plan_lir;
    plan_flush_next    = plan_flush;
    plan_byte_next     = plan_byte;
    cmd_pop            = 1'b0;
    fin_go             = 1'b0;
    pend_go            = 1'b0;
    fin_act            = plan_act;
    fin_lir            = plan_lir;
    fin_flush          = plan_flush;
    fin_byte           = plan_byte;

    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop       = 1'b1;
          mode_next     = dec_mode;
          after_cr_next = !cmd.flush && cmd.is_cr;
          if (!cmd.flush && !cmd.is_cr && !cmd.is_lf) begin
            line_open_next = 1'b1;
          end
          // Append to the pending trim run, saturating
          if (do_push) begin
            if (pcnt >= PCNT_W'(PENDING_DEPTH)) begin
              overflow_seen_next = 1'b1;
            end else begin
              kinds_next[pcnt[PIDX_W-1:0]] = push_kind;
              pcnt_next      = pcnt + PCNT_W'(1);
              tail_kind_next = push_kind;
            end
          end
          if (dec_res) begin
            fin_act         = dec_act;
            fin_lir         = dec_lir;
            fin_flush       = cmd.flush;
            fin_byte        = cmd.data;
            plan_act_next   = dec_act;
            plan_lir_next   = dec_lir;
            plan_flush_next = cmd.flush;
            plan_byte_next  = cmd.data;
            if (dec_pend == '0 && out_free) begin
              fin_go = 1'b1;
            end else begin
              pend_left_next = dec_pend;
              state_next     = (dec_pend != '0) ? ST_PEND : ST_FIN;
            end
          end
        end
      end
      ST_PEND: begin
        // Release one pending entry per transfer slot
        if (out_free) begin
          pend_go        = 1'b1;
          kinds_next     = kinds >> 1;
          pend_left_next = pend_left - PCNT_W'(1);
          if (pend_left == PCNT_W'(1)) begin
            state_next = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          fin_go     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase

    // Close out the final result of a command
    if (fin_go) begin
      case (fin_act)
        KIND_CHAR: begin
          kinds_next        = '0;
          pcnt_next         = '0;
          tail_kind_next    = 1'b0;
          content_seen_next = 1'b1;
        end
        KIND_FEND: begin
          col_count_next    = col_inc;
          mode_next         = MODE_START;
          kinds_next        = '0;
          pcnt_next         = '0;
          tail_kind_next    = 1'b0;
          content_seen_next = 1'b0;
          if (fin_lir) begin
            col_max_next   = (col_inc > col_max) ? col_inc : col_max;
            row_count_next = (row_count != ROW_LIMIT) ? row_count + ROW_W'(1) : row_count;
            col_count_next = '0;
            line_open_next = 1'b0;
          end
          if (fin_flush) begin
            plan_act_next = KIND_TEND;
            state_next    = ST_FIN;
          end
        end
        KIND_TEND: begin
          mode_next          = MODE_START;
          kinds_next         = '0;
          pcnt_next          = '0;
          tail_kind_next     = 1'b0;
          content_seen_next  = 1'b0;
          line_open_next     = 1'b0;
          after_cr_next      = 1'b0;
          row_count_next     = '0;
          col_count_next     = '0;
          col_max_next       = '0;
          overflow_seen_next = 1'b0;
          state_next         = ST_IDLE;
        end
        default: ;
      endcase
    end
  end

  // Build the result item
  always_comb begin
    emit.row_index        = row_count;
    emit.pending_overflow = overflow_seen;
    if (pend_go) begin
      emit.kind         = KIND_CHAR;
      emit.char_value   = kinds[0] ? text_delim : CH_SP;
      emit.column_index = COL_W'(col_count);
      emit.last_in_row  = 1'b0;
      emit.last         = 1'b0;
    end else begin
      emit.kind         = fin_act;
      emit.char_value   = (fin_act == KIND_CHAR) ? fin_byte : 8'h00;
      emit.column_index = (fin_act == KIND_TEND) ? COL_W'(col_max) : COL_W'(col_count);
      emit.last_in_row  = (fin_act == KIND_FEND) && fin_lir;
      emit.last         = !((fin_act == KIND_FEND) && fin_flush);
    end
  end

  // Output register
  always_comb begin
    out_valid_next = out_valid;
    out_data_next  = out_data;
    if (pend_go || fin_go) begin
      out_valid_next = 1'b1;
      out_data_next  = emit;
    end else if (out_ch.ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      mode          <= MODE_START;
      kinds         <= '0;
      pcnt          <= '0;
      tail_kind     <= 1'b0;
      content_seen  <= 1'b0;
      line_open     <= 1'b0;
      after_cr      <= 1'b0;
      row_count     <= '0;
      col_count     <= '0;
      col_max       <= '0;
      overflow_seen <= 1'b0;
      pend_left     <= '0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      mode          <= mode_next;
      kinds         <= kinds_next;
      pcnt          <= pcnt_next;
      tail_kind     <= tail_kind_next;
      content_seen  <= content_seen_next;
      line_open     <= line_open_next;
      after_cr      <= after_cr_next;
      row_count     <= row_count_next;
      col_count     <= col_count_next;
      col_max       <= col_max_next;
      overflow_seen <= overflow_seen_next;
      pend_left     <= pend_left_next;
      out_valid     <= out_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    plan_act   <= plan_act_next;
    plan_lir   <= plan_lir_next;
    plan_flush <= plan_flush_next;
    plan_byte  <= plan_byte_next;
    out_data   <= out_data_next;
  end

  assign out_ch.valid            = out_valid;
  assign out_ch.kind             = out_data.kind;
  assign out_ch.char_value       = out_data.char_value;
  assign out_ch.row_index        = out_data.row_index;
  assign out_ch.column_index     = out_data.column_index;
  assign out_ch.last_in_row      = out_data.last_in_row;
  assign out_ch.pending_overflow = out_data.pending_overflow;
  assign out_ch.last             = out_data.last;

  assign stat.idle      = (state == ST_IDLE);
  assign stat.line_open = line_open;

endmodule

// ===== tb/sv/tb_csv_field_tokenizer.sv =====
// Self-checking testbench for the CSV field tokenizer: byte stimulus, token prediction, compare.
`timescale 1ns / 1ps
module tb_csv_field_tokenizer;
  import csvt_pkg::*;

  localparam int PEND_DEPTH   = 32;
  localparam int COL_LIMIT    = 1024;
  localparam int HOLD_CYCLES  = 250;
  localparam int DRAIN_CYCLES = 20;
  localparam int STALL_LIMIT  = 2000;
  localparam int PHASE_ITEMS  = 25;
  localparam int MAX_REPORTS  = 50;
  // Index past the register list; writes to it must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

  // Predicts the token stream from accepted bytes and checks the block's output
  class token_board;
    logic [7:0]            sep_a, sep_b, delim;
    mode_t                 mode;
    logic [PEND_DEPTH-1:0] pend_kinds;
    int                    pend_cnt;
    bit                    content_seen, line_open, after_cr, ovf_seen;
    logic [ROW_W-1:0]      row_cnt;
    int                    col_cnt, col_max;
    res_t                  tokens_due[$];
    int                    errors;

    function new();
      sep_a  = SEP_RESET;
      sep_b  = SEP_RESET;
      delim  = DELIM_RESET;
      errors = 0;
      clear_stream();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] v);
      case (idx)
        REG_SEP_A: sep_a = v;
        REG_SEP_B: sep_b = v;
        REG_DELIM: delim = v;
        default: ;
      endcase
    endfunction

    function void clear_field();
      mode         = MODE_START;
      pend_kinds   = '0;
      pend_cnt     = 0;
      content_seen = 1'b0;
    endfunction

    function void clear_stream();
      clear_field();
      line_open = 1'b0;
      after_cr  = 1'b0;
      row_cnt   = '0;
      col_cnt   = 0;
      col_max   = 0;
      ovf_seen  = 1'b0;
    endfunction

    function void emit(kind_t k, logic [7:0] ch, int col, bit lir);
      res_t r;
      r.kind             = k;
      r.char_value       = ch;
      r.row_index        = row_cnt;
      r.column_index     = COL_W'(col);
      r.last_in_row      = lir;
      r.pending_overflow = ovf_seen;
      r.last             = 1'b0;
      tokens_due = {tokens_due, r};
    endfunction

    function void push_entry(bit is_delim);
      if (pend_cnt >= PEND_DEPTH) begin
        ovf_seen = 1'b1;
        return;
      end
      pend_kinds[pend_cnt] = is_delim;
      pend_cnt++;
    endfunction

    function void emit_pending(int cnt);
      for (int i = 0; i < cnt; i++) begin
        emit(KIND_CHAR, pend_kinds[i] ? delim : CH_SP, col_cnt, 1'b0);
      end
    endfunction

    // Two-stage cleanup: collapse whitespace, hold trimmable bytes until content follows
    function void feed(logic [7:0] b);
      if (b == CH_SP || b == CH_TAB) begin
        if (!content_seen && pend_cnt == 0) return;
        if (pend_cnt > 0 && pend_kinds[pend_cnt-1] == 1'b0) return;
        push_entry(1'b0);
      end else if (b == delim) begin
        push_entry(1'b1);
      end else begin
        if (content_seen) emit_pending(pend_cnt);
        pend_kinds   = '0;
        pend_cnt     = 0;
        content_seen = 1'b1;
        emit(KIND_CHAR, b, col_cnt, 1'b0);
      end
    endfunction

    function void end_field(bit lir);
      int cnt;
      if (!content_seen) begin
        // a field of trimmable bytes only keeps them, minus a trailing space
        cnt = pend_cnt;
        if (cnt > 0 && pend_kinds[cnt-1] == 1'b0) cnt--;
        emit_pending(cnt);
      end
      emit(KIND_FEND, 8'h00, col_cnt, lir);
      if (col_cnt < COL_LIMIT) col_cnt++;
      clear_field();
    endfunction

    function void end_line();
      if (!line_open) return;
      end_field(1'b1);
      if (col_cnt > col_max) col_max = col_cnt;
      if (row_cnt != ROW_LIMIT) row_cnt++;
      col_cnt   = 0;
      line_open = 1'b0;
    endfunction

    // Work out the tokens caused by one accepted input transfer
    function void note_byte(bit flush, logic [7:0] b);
      int   before_n;
      bit   sep;
      res_t r;
      before_n = tokens_due.size();
      if (flush) begin
        end_line();
        emit(KIND_TEND, 8'h00, col_max, 1'b0);
        clear_stream();
      end else if (after_cr && b == CH_LF) begin
        after_cr = 1'b0;
      end else begin
        after_cr = 1'b0;
        if (b == CH_CR) begin
          end_line();
          after_cr = 1'b1;
        end else if (b == CH_LF) begin
          end_line();
        end else begin
          sep = (b == sep_a) || (b == sep_b);
          if (!line_open) begin
            line_open = 1'b1;
            col_cnt   = 0;
            clear_field();
          end
          if (mode == MODE_QUOTED) begin
            if (b == delim) mode = MODE_PLAIN;
            feed(b);
          end else if (mode == MODE_START && b == delim) begin
            mode = MODE_QUOTED;
            feed(b);
          end else if (sep) begin
            end_field(1'b0);
          end else begin
            mode = MODE_PLAIN;
            feed(b);
          end
        end
      end
      // Mark the final token of this transfer
      if (tokens_due.size() > before_n) begin
        r      = tokens_due[tokens_due.size()-1];
        r.last = 1'b1;
        tokens_due[tokens_due.size()-1] = r;
      end
    endfunction

    function void report(string name, longint want, longint got);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    endfunction

    function void check_token(res_t got);
      res_t want;
      if (tokens_due.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected token: expected none, actual kind %0d char %0d",
                   $time, got.kind, got.char_value);
        return;
      end
      want = tokens_due.pop_front();
      if (got.kind != want.kind) report("kind", want.kind, got.kind);
      if (got.char_value != want.char_value)
        report("char_value", want.char_value, got.char_value);
      if (got.row_index != want.row_index) report("row_index", want.row_index, got.row_index);
      if (got.column_index != want.column_index)
        report("column_index", want.column_index, got.column_index);
      if (got.last_in_row != want.last_in_row)
        report("last_in_row", want.last_in_row, got.last_in_row);
      if (got.pending_overflow != want.pending_overflow)
        report("pending_overflow", want.pending_overflow, got.pending_overflow);
      if (got.last != want.last) report("last", want.last, got.last);
    endfunction
  endclass

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  csvt_in_if  byte_ch();
  csvt_out_if token_ch();

  token_board board = new();
  bit         steady   = 1'b0;
  bit         hold_req = 1'b0;

  csv_field_tokenizer #(
    .PENDING_DEPTH(PEND_DEPTH),
    .MAX_COLUMNS  (COL_LIMIT)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (byte_ch),
    .out_ch   (token_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 99) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Bytes weighted toward the ones the tokenizer reacts to
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return 8'h61 + 8'($urandom_range(0, 25));
    if (r < 45) return CH_SP;
    if (r < 50) return CH_TAB;
    if (r < 60) return board.sep_a;
    if (r < 65) return board.sep_b;
    if (r < 75) return board.delim;
    if (r < 80) return CH_CR;
    if (r < 85) return CH_LF;
    return 8'($urandom_range(0, 255));
  endfunction

  // Offer one item and hold it until the transfer happens
  task automatic send_item(bit flush, logic [7:0] b);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_ch.valid   <= 1'b1;
    byte_ch.op      <= flush;
    byte_ch.in_byte <= b;
    do @(posedge clk); while (!byte_ch.ready);
    board.note_byte(flush, b);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(1'b0, s[i]);
  endtask

  task automatic send_run(logic [7:0] b, int n);
    for (int i = 0; i < n; i++) send_item(1'b0, b);
  endtask

  // Drop valid, wait for every token, then let the block settle
  task automatic drain();
    byte_ch.valid <= 1'b0;
    while (board.tokens_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    board.set_reg(idx, v);
  endtask

  task automatic write_regs(logic [7:0] sa, logic [7:0] sb, logic [7:0] dl);
    write_reg(REG_SEP_A, sa);
    write_reg(REG_SEP_B, sb);
    write_reg(REG_DELIM, dl);
    write_reg(REG_NONE, 8'($urandom_range(0, 255)));
    cfg_we <= 1'b0;
  endtask

  // Random bytes with bursts of trimmable runs and the odd end of input
  task automatic send_random(int count);
    int sent;
    int r;
    int n;
    sent = 0;
    while (sent < count) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        n = $urandom_range(3, 12);
        for (int i = 0; i < n; i++)
          send_item(1'b0, $urandom_range(0, 1) ? board.delim : CH_SP);
        sent += n;
      end else if (r < 11) begin
        send_item(1'b1, 8'($urandom_range(0, 255)));
        sent++;
      end else begin
        send_item(1'b0, pick_byte());
        sent++;
      end
    end
  endtask

  // Result side: random stalls, plus one long hold-off on request
  initial begin : token_sink
    int   stall;
    res_t got;
    stall = 0;
    token_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (token_ch.valid && token_ch.ready) begin
        got.kind             = kind_t'(token_ch.kind);
        got.char_value       = token_ch.char_value;
        got.row_index        = token_ch.row_index;
        got.column_index     = token_ch.column_index;
        got.last_in_row      = token_ch.last_in_row;
        got.pending_overflow = token_ch.pending_overflow;
        got.last             = token_ch.last;
        board.check_token(got);
      end
      if (hold_req) begin
        stall    = HOLD_CYCLES;
        hold_req = 1'b0;
      end else if (stall == 0 && !steady) begin
        stall = pick_gap();
      end
      if (stall > 0) begin
        token_ch.ready <= 1'b0;
        stall--;
      end else begin
        token_ch.ready <= 1'b1;
      end
    end
  end

  // End the run when no transfer happens on either side for too long
  initial begin : watchdog
    int stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk);
      if ((byte_ch.valid && byte_ch.ready) || (token_ch.valid && token_ch.ready))
        stalled = 0;
      else
        stalled++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    byte_ch.valid   <= 1'b0;
    byte_ch.op      <= 1'b0;
    byte_ch.in_byte <= 8'h00;
    cfg_we          <= 1'b0;
    cfg_index       <= REG_SEP_A;
    cfg_data        <= 8'h00;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Whitespace cleanup, protected fields, separator at line end, CR LF,
    // empty lines, a field of trimmable bytes only, an unclosed protected field
    send_text(" a\t b ,\"x,y\" ,,\r\n\n\" \" \r\r\"");
    send_item(1'b0, 8'hFF);
    send_item(1'b0, 8'h00);
    send_item(1'b1, 8'($urandom_range(0, 255)));
    drain();

    // Pending store overflow, then end of input with a full store
    send_text("a");
    send_run(DELIM_RESET, 40);
    send_text("b,");
    send_run(DELIM_RESET, 40);
    send_item(1'b1, 8'h00);
    drain();

    // Receiver holds off while the sender keeps offering
    write_regs(SEP_RESET, SEP_RESET, DELIM_RESET);
    steady   = 1'b1;
    hold_req = 1'b1;
    send_random(PHASE_ITEMS);
    drain();
    steady = 1'b0;

    write_regs(8'h3B, CH_TAB, 8'h27);
    send_random(PHASE_ITEMS);
    drain();

    write_regs(8'h00, 8'hFF, 8'h00);
    send_random(PHASE_ITEMS);
    drain();

    write_regs(8'hFF, 8'h00, 8'hFF);
    steady = 1'b1;
    send_random(PHASE_ITEMS);
    drain();
    steady = 1'b0;

    // CR as separator and LF as delimiter: line ends must still win
    write_regs(CH_CR, CH_SP, CH_LF);
    send_random(PHASE_ITEMS);
    drain();

    write_regs(SEP_RESET, CH_TAB, CH_SP);
    send_random(PHASE_ITEMS);
    send_item(1'b1, 8'h00);
    drain();

    if (board.errors == 0 && board.tokens_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
